### rtl/core/sms_api_frame_builder_core_macros.svh
// Assertion macros used by the checker of the frame builder.
`ifndef SMS_API_FRAME_BUILDER_CORE_MACROS_SVH
`define SMS_API_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfb assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfb assertion failed");

`endif

### rtl/core/sfb_pkg.sv
package sfb_pkg;

  localparam int PHONE_FIELD_BYTES_DEF = 20;
  localparam int MAX_PAYLOAD_DEF       = 160;

  localparam logic [7:0] START_DELIM  = 8'h7E;
  localparam logic [7:0] FRAME_TYPE   = 8'h1F;
  localparam logic [7:0] HEADER_EXTRA = 8'd23;

  localparam logic [7:0] FRAME_IDENT_RST = 8'd1;
  localparam logic [7:0] OPTION_BITS_RST = 8'd0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_IDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_BITS = 2'd1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PHONE   = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_PHONE_LONG  = 3'd1,
    ERR_PAYLOAD_OVF = 3'd2,
    ERR_NO_FRAME    = 3'd3,
    ERR_LEN_MISMATCH = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    HS_DELIM   = 3'd0,
    HS_LEN_HI  = 3'd1,
    HS_LEN_LO  = 3'd2,
    HS_TYPE    = 3'd3,
    HS_IDENT   = 3'd4,
    HS_OPTIONS = 3'd5
  } hdr_step_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [7:0] payload_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       frame_done;
    err_t       err_code;
  } out_item_t;

endpackage

### rtl/core/sms_api_frame_builder_core.sv
// An accepted item waits in a work register; each result byte is registered in the output
// register. Phone and payload items without padding flow at one item per cycle, back to back,
// while out_ready holds no byte back. A start item emits six header bytes; phone padding adds
// one zero byte per missing phone byte, up to PHONE_FIELD_BYTES, before the first payload byte
// or the checksum. Reset: synchronous, active low; clears the frame state and the output valid
// flag and loads frame_ident = 1, option_bits = 0.
module sms_api_frame_builder_core
  import sfb_pkg::*;
#(
  parameter int PHONE_FIELD_BYTES = PHONE_FIELD_BYTES_DEF,
  parameter int MAX_PAYLOAD       = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PH_W = $clog2(PHONE_FIELD_BYTES + 1);
  localparam logic [PH_W-1:0] PHONE_LIM = PH_W'(PHONE_FIELD_BYTES);
  localparam logic [7:0]      PAY_LIM   = 8'(MAX_PAYLOAD);

  logic [7:0]      frame_ident_r, option_bits_r;
  logic [7:0]      running_sum_r, running_sum_nxt;
  logic [PH_W-1:0] phone_count_r, phone_count_nxt;
  logic [7:0]      payload_count_r, payload_count_nxt;
  logic [7:0]      declared_count_r, declared_count_nxt;
  logic            frame_open_r, frame_open_nxt;
  hdr_step_t       hdr_step_r, hdr_step_nxt;

  logic            work_valid_r;
  in_item_t        work_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  out_item_t       res;
  err_t            err;
  logic            item_last;
  logic            can_load;
  logic            fire;
  logic            in_fire;

  assign can_load  = !out_valid_r || out_ready;
  assign fire      = work_valid_r && can_load;
  assign in_ready  = !work_valid_r || (fire && item_last);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    res                = '0;
    err                = ERR_OK;
    item_last          = 1'b0;
    running_sum_nxt    = running_sum_r;
    phone_count_nxt    = phone_count_r;
    payload_count_nxt  = payload_count_r;
    declared_count_nxt = declared_count_r;
    frame_open_nxt     = frame_open_r;
    hdr_step_nxt       = hdr_step_r;

    case (work_r.op)
      OP_START: begin
        if (work_r.payload_len > PAY_LIM) err = ERR_PAYLOAD_OVF;
      end
      OP_PHONE: begin
        if (!frame_open_r) err = ERR_NO_FRAME;
        else if (phone_count_r >= PHONE_LIM || payload_count_r != 8'd0) err = ERR_PHONE_LONG;
      end
      OP_PAYLOAD: begin
        if (!frame_open_r) err = ERR_NO_FRAME;
        else if (payload_count_r >= declared_count_r || payload_count_r >= PAY_LIM) begin
          err = ERR_PAYLOAD_OVF;
        end
      end
      OP_END: begin
        if (!frame_open_r) err = ERR_NO_FRAME;
        else if (payload_count_r != declared_count_r) err = ERR_LEN_MISMATCH;
      end
      default: err = ERR_OK;
    endcase

    if (err != ERR_OK) begin
      res.err_code = err;
      res.run_last = 1'b1;
      item_last    = 1'b1;
    end else begin
      res.byte_valid = 1'b1;
      case (work_r.op)
        OP_START: begin
          case (hdr_step_r)
            HS_DELIM: begin
              res.out_byte = START_DELIM;
              hdr_step_nxt = HS_LEN_HI;
            end
            HS_LEN_HI: begin
              res.out_byte = 8'd0;
              hdr_step_nxt = HS_LEN_LO;
            end
            HS_LEN_LO: begin
              res.out_byte = HEADER_EXTRA + work_r.payload_len;
              hdr_step_nxt = HS_TYPE;
            end
            HS_TYPE: begin
              res.out_byte = FRAME_TYPE;
              hdr_step_nxt = HS_IDENT;
            end
            HS_IDENT: begin
              res.out_byte = frame_ident_r;
              hdr_step_nxt = HS_OPTIONS;
            end
            HS_OPTIONS: begin
              res.out_byte       = option_bits_r;
              res.run_last       = 1'b1;
              item_last          = 1'b1;
              hdr_step_nxt       = HS_DELIM;
              frame_open_nxt     = 1'b1;
              phone_count_nxt    = '0;
              payload_count_nxt  = 8'd0;
              declared_count_nxt = work_r.payload_len;
              running_sum_nxt    = FRAME_TYPE + frame_ident_r + option_bits_r;
            end
            default: hdr_step_nxt = HS_DELIM;
          endcase
        end
        OP_PHONE: begin
          res.out_byte    = work_r.data_byte;
          res.run_last    = 1'b1;
          item_last       = 1'b1;
          phone_count_nxt = phone_count_r + 1'b1;
          running_sum_nxt = running_sum_r + work_r.data_byte;
        end
        OP_PAYLOAD: begin
          if (phone_count_r < PHONE_LIM) begin
            phone_count_nxt = phone_count_r + 1'b1;
          end else begin
            res.out_byte      = work_r.data_byte;
            res.run_last      = 1'b1;
            item_last         = 1'b1;
            payload_count_nxt = payload_count_r + 8'd1;
            running_sum_nxt   = running_sum_r + work_r.data_byte;
          end
        end
        OP_END: begin
          if (phone_count_r < PHONE_LIM) begin
            phone_count_nxt = phone_count_r + 1'b1;
          end else begin
            res.out_byte   = ~running_sum_r;
            res.run_last   = 1'b1;
            res.frame_done = 1'b1;
            item_last      = 1'b1;
            frame_open_nxt = 1'b0;
          end
        end
        default: item_last = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ident_r    <= FRAME_IDENT_RST;
      option_bits_r    <= OPTION_BITS_RST;
      running_sum_r    <= 8'd0;
      phone_count_r    <= '0;
      payload_count_r  <= 8'd0;
      declared_count_r <= 8'd0;
      frame_open_r     <= 1'b0;
      hdr_step_r       <= HS_DELIM;
      work_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_IDENT: frame_ident_r <= cfg_data;
          REG_OPTION_BITS: option_bits_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        running_sum_r    <= running_sum_nxt;
        phone_count_r    <= phone_count_nxt;
        payload_count_r  <= payload_count_nxt;
        declared_count_r <= declared_count_nxt;
        frame_open_r     <= frame_open_nxt;
        hdr_step_r       <= hdr_step_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        work_valid_r <= 1'b1;
      end else if (fire && item_last) begin
        work_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) work_r <= in_item;
    if (fire) out_item_r <= res;
  end

endmodule

### rtl/core/sfb_checker.sv
`include "sms_api_frame_builder_core_macros.svh"

module sfb_checker
  import sfb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic done_shape_ok;
  logic err_shape_ok;
  logic err_flag;

  assign done_shape_ok = out_item.byte_valid && out_item.run_last && out_item.err_code == ERR_OK;
  assign err_shape_ok  = out_item.run_last && out_item.out_byte == 8'd0 && !out_item.frame_done
                         && out_item.err_code != ERR_OK;
  assign err_flag      = out_item.err_code != ERR_OK;

  `SFB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
  `SFB_ASSERT_NOW(a_done_is_ok, clk, rst_n, out_valid && out_item.frame_done, done_shape_ok)
  `SFB_ASSERT_NOW(a_err_shape, clk, rst_n, out_valid && !out_item.byte_valid, err_shape_ok)
  `SFB_ASSERT_NOW(a_err_no_byte, clk, rst_n, out_valid && err_flag, !out_item.byte_valid)

endmodule

bind sms_api_frame_builder_core sfb_checker u_sfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam out_item_t R_NONE = '0;
  localparam out_item_t R_NO_FRAME = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                       frame_done: 1'b0, err_code: ERR_NO_FRAME};
  localparam out_item_t R_OVF = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                  frame_done: 1'b0, err_code: ERR_PAYLOAD_OVF};
  localparam out_item_t R_PHONE = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                    frame_done: 1'b0, err_code: ERR_PHONE_LONG};
  localparam out_item_t R_LEN = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                  frame_done: 1'b0, err_code: ERR_LEN_MISMATCH};

  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    '{'{OP_PHONE,   8'hFF, 8'h00}, 1,  1'b1, R_NO_FRAME},
    '{'{OP_PAYLOAD, 8'h00, 8'hFF}, 1,  1'b1, R_NO_FRAME},
    '{'{OP_END,     8'hA5, 8'h5A}, 1,  1'b1, R_NO_FRAME},
    '{'{OP_START,   8'h00, 8'd161}, 1, 1'b1, R_OVF},
    '{'{OP_START,   8'hFF, 8'hFF}, 1,  1'b1, R_OVF},
    '{'{OP_START,   8'h00, 8'd0},  1,  1'b0, R_NONE},
    '{'{OP_PAYLOAD, 8'hAA, 8'h00}, 1,  1'b1, R_OVF},
    '{'{OP_END,     8'h00, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_START,   8'h00, 8'd2},  1,  1'b0, R_NONE},
    '{'{OP_END,     8'h00, 8'h00}, 1,  1'b1, R_LEN},
    '{'{OP_PHONE,   8'h00, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_PHONE,   8'hFF, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_PAYLOAD, 8'h55, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_PHONE,   8'h33, 8'h00}, 1,  1'b1, R_PHONE},
    '{'{OP_PAYLOAD, 8'hAA, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_PAYLOAD, 8'h01, 8'h00}, 1,  1'b1, R_OVF},
    '{'{OP_END,     8'h00, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_START,   8'h00, 8'd160}, 1, 1'b0, R_NONE},
    '{'{OP_PAYLOAD, 8'h7F, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_START,   8'h00, 8'd1},  1,  1'b0, R_NONE},
    '{'{OP_PHONE,   8'h5A, 8'h00}, 20, 1'b0, R_NONE},
    '{'{OP_PHONE,   8'hA5, 8'h00}, 1,  1'b1, R_PHONE},
    '{'{OP_PAYLOAD, 8'h80, 8'h00}, 1,  1'b0, R_NONE},
    '{'{OP_END,     8'hFF, 8'hFF}, 1,  1'b0, R_NONE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [7:0] ident_reg = FRAME_IDENT_RST;
  logic [7:0] opts_reg = OPTION_BITS_RST;
  logic [7:0] run_sum = '0;
  logic [4:0] phone_cnt = '0;
  logic [7:0] pay_cnt = '0;
  logic [7:0] decl_cnt = '0;
  logic       frame_open = 1'b0;

  out_item_t item_bytes [$];
  out_item_t pending_bytes [$];
  out_item_t want;

  int  mismatches = 0;
  int  items_sent = 0;
  int  bytes_checked = 0;
  int  frames_closed = 0;
  int  rx_hold_left = 0;
  bit  quiet = 1'b0;

  sms_api_frame_builder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b, input logic last, input logic done);
    item_bytes.push_back('{out_byte: b, byte_valid: 1'b1, run_last: last,
                           frame_done: done, err_code: ERR_OK});
  endfunction

  function automatic void add_err(input err_t e);
    item_bytes.push_back('{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                           frame_done: 1'b0, err_code: e});
  endfunction

  function automatic void pad_phone_field();
    while (phone_cnt < PHONE_FIELD_BYTES_DEF) begin
      add_byte(8'h00, 1'b0, 1'b0);
      phone_cnt++;
    end
  endfunction

  function automatic void predict_frame_bytes(input in_item_t it);
    item_bytes.delete();
    case (it.op)
      OP_START: begin
        if (it.payload_len > MAX_PAYLOAD_DEF) begin
          add_err(ERR_PAYLOAD_OVF);
        end else begin
          frame_open = 1'b1;
          phone_cnt = '0;
          pay_cnt = '0;
          decl_cnt = it.payload_len;
          run_sum = FRAME_TYPE + ident_reg + opts_reg;
          add_byte(START_DELIM, 1'b0, 1'b0);
          add_byte(8'h00, 1'b0, 1'b0);
          add_byte(HEADER_EXTRA + it.payload_len, 1'b0, 1'b0);
          add_byte(FRAME_TYPE, 1'b0, 1'b0);
          add_byte(ident_reg, 1'b0, 1'b0);
          add_byte(opts_reg, 1'b1, 1'b0);
        end
      end
      OP_PHONE: begin
        if (!frame_open) begin
          add_err(ERR_NO_FRAME);
        end else if (phone_cnt >= PHONE_FIELD_BYTES_DEF || pay_cnt != 0) begin
          add_err(ERR_PHONE_LONG);
        end else begin
          phone_cnt++;
          run_sum = run_sum + it.data_byte;
          add_byte(it.data_byte, 1'b1, 1'b0);
        end
      end
      OP_PAYLOAD: begin
        if (!frame_open) begin
          add_err(ERR_NO_FRAME);
        end else if (pay_cnt >= decl_cnt || pay_cnt >= MAX_PAYLOAD_DEF) begin
          add_err(ERR_PAYLOAD_OVF);
        end else begin
          pad_phone_field();
          pay_cnt++;
          run_sum = run_sum + it.data_byte;
          add_byte(it.data_byte, 1'b1, 1'b0);
        end
      end
      default: begin
        if (!frame_open) begin
          add_err(ERR_NO_FRAME);
        end else if (pay_cnt != decl_cnt) begin
          add_err(ERR_LEN_MISMATCH);
        end else begin
          pad_phone_field();
          add_byte(~run_sum, 1'b1, 1'b1);
          frame_open = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic in_item_t mk(input op_t op, input logic [7:0] d, input logic [7:0] l);
    in_item_t it;
    it.op = op;
    it.data_byte = d;
    it.payload_len = l;
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_res = '0);
    if (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_bytes(it);
    if (typed) pending_bytes.push_back(typed_res);
    else foreach (item_bytes[i]) pending_bytes.push_back(item_bytes[i]);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_regs(input logic [7:0] ident, input logic [7:0] opts);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_IDENT;
    cfg_data <= ident;
    @(negedge clk);
    cfg_index <= REG_OPTION_BITS;
    cfg_data <= opts;
    @(negedge clk);
    cfg_index <= REG_SPARE_A;
    cfg_data <= 8'hFF;
    @(negedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ident_reg = ident;
    opts_reg = opts;
  endtask

  task automatic send_frame(input int force_len = -1);
    int plen;
    int nphone;
    int early_end;
    int i;
    if (force_len < 0 && $urandom_range(0, 99) < 5) begin
      push_item(mk(OP_START, 8'($urandom), 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255))));
      return;
    end
    if (force_len >= 0) plen = force_len;
    else if ($urandom_range(0, 99) < 85) plen = $urandom_range(0, 6);
    else plen = $urandom_range(7, 40);
    push_item(mk(OP_START, 8'($urandom), 8'(plen)));
    nphone = ($urandom_range(0, 99) < 8) ? PHONE_FIELD_BYTES_DEF + 1
                                          : $urandom_range(0, PHONE_FIELD_BYTES_DEF);
    repeat (nphone) push_item(mk(OP_PHONE, 8'($urandom), 8'($urandom)));
    early_end = (plen > 0 && $urandom_range(0, 99) < 8) ? $urandom_range(0, plen - 1) : -1;
    for (i = 0; i < plen; i++) begin
      if (i == early_end) push_item(mk(OP_END, 8'($urandom), 8'($urandom)));
      push_item(mk(OP_PAYLOAD, 8'($urandom), 8'($urandom)));
      if (i == 0 && $urandom_range(0, 99) < 6)
        push_item(mk(OP_PHONE, 8'($urandom), 8'($urandom)));
    end
    if (force_len >= 0 || $urandom_range(0, 99) < 8)
      push_item(mk(OP_PAYLOAD, 8'($urandom), 8'($urandom)));
    // abandon the frame now and then
    if ($urandom_range(0, 99) < 5) return;
    push_item(mk(OP_END, 8'($urandom), 8'($urandom)));
    if ($urandom_range(0, 99) < 10) wait_drained();
  endtask

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h err_code %0d", out_item.out_byte,
               out_item.err_code);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_item.frame_done) frames_closed++;
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
          mismatches++;
        end
        if (out_item.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_item.byte_valid);
          mismatches++;
        end
        if (out_item.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_item.run_last);
          mismatches++;
        end
        if (out_item.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, out_item.frame_done);
          mismatches++;
        end
        if (out_item.err_code !== want.err_code) begin
          $error("err_code: expected %0d, got %0d", want.err_code, out_item.err_code);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int phase;
    int r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < 24; r++)
      repeat (dir_rows[r].reps) push_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);

    for (phase = 1; phase <= 4; phase++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      case (phase)
        1: load_regs(8'h00, 8'h00);
        2: load_regs(8'hFF, 8'hFF);
        default: load_regs(8'($urandom), 8'($urandom));
      endcase
      @(posedge clk);
      quiet = (phase == 2);
      if (phase == 1) rx_hold_left = 400;
      @(negedge clk);
      if (phase == 2) send_frame(MAX_PAYLOAD_DEF);
      while (items_sent < 44 + phase * 110) begin
        if ($urandom_range(0, 99) < 10)
          repeat ($urandom_range(1, 3))
            push_item(mk(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom)));
        send_frame();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items, %0d result bytes, %0d completed frames,", items_sent,
             bytes_checked, frames_closed);
    $display("four register settings, a long output stall and drained pauses.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
